// ===== src/nat_pkg.sv =====
// Package for the node alias table: sizes, codes, payload types and generator helpers.
package nat_pkg;

  // table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int ID_W    = 48;
  localparam int ALIAS_W = 12;
  localparam int STAMP_W = 32;
  localparam int MODE_W  = 3;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD          = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALIAS_BY_ID  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ID_BY_ALIAS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GENERATE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DUMP         = 3'd5;

  // generator constants
  localparam logic [ID_W-1:0] LCG_ADD = 48'h01B0CA37ABA9;
  localparam int              LCG_SHIFT = 9;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    node_id;
    logic [ALIAS_W-1:0] alias_in;
    logic [STAMP_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    result_id;
    logic [ALIAS_W-1:0] result_alias;
    logic               entry_valid;
    logic               last;
  } rsp_t;

  // one table slot as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]    node_id;
    logic [ALIAS_W-1:0] alias_val;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // XOR fold of the four 12-bit groups of a seed
  function automatic logic [ALIAS_W-1:0] alias_fold(input logic [ID_W-1:0] s);
    return s[11:0] ^ s[23:12] ^ s[35:24] ^ s[47:36];
  endfunction

  // seed * 513 + LCG_ADD, modulo 2^48
  function automatic logic [ID_W-1:0] lcg_next(input logic [ID_W-1:0] s);
    return (s << LCG_SHIFT) + s + LCG_ADD;
  endfunction

endpackage

// ===== src/node_alias_table_with_generator_core.sv =====
// Top level of the node alias table with alias generator.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one command per
//   transaction: add, remove, alias-by-id, id-by-alias, generate or dump.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns results; the final
//   result of a command has last set. Add, remove and unknown codes give none.
//   cfg_wr_en/cfg_wr_data load the generator seed; the user must do this only while idle (no block check).
// Scan:
//   Every command that does work scans all ENTRIES slots, one RAM read a cycle
//   while a dump is not paused (see Stall). Generate rescans for each rejected
//   candidate and steps past a zero candidate without a scan; ignored commands
//   do not scan. The RAM read port limits the scan.
// Reset: rst clears the slot valid flags (slots read empty), seed and control.
// Stall:
//   A result waits in the output register while rsp_stall is high; a dump
//   pauses its scan while both the output register and the lookahead slot
//   are full. New commands are taken once the previous one is finished.
module node_alias_table_with_generator_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  nat_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output nat_pkg::rsp_t rsp_data,
  input  logic          cfg_wr_en,
  input  logic [47:0]   cfg_wr_data
);
  import nat_pkg::*;

  state_t            state, state_next;
  req_t              op;
  logic [CNT_W-1:0]  iss_cnt;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  entry_t            found_ent;
  logic              best_vld;
  logic [STAMP_W-1:0] best_stamp;
  logic [IDX_W-1:0]  best_idx;
  logic              hold_vld;
  rsp_t              hold;
  rsp_t              res, res_next;
  logic              res_load;
  logic              out_vld;
  rsp_t              out_q, out_next;
  logic              out_load;
  logic [ID_W-1:0]   running_seed;
  logic [ENTRIES-1:0] valid_bits;

  logic              accept, start_ok, scan_clear, retry, seed_step;
  logic              issue, eval_block, eval_fire, out_free, out_take;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_ent;
  entry_t            rd_ent;
  logic              ent_vld, occupied, match;
  logic [ID_W-1:0]   e_id;
  logic [ALIAS_W-1:0] e_al;
  logic [ALIAS_W-1:0] gen_alias;
  logic              is_dump, is_gen, iss_done;

  // table storage
  nat_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (issue),
    .rd_addr(iss_cnt[IDX_W-1:0]),
    .rd_data(rd_ent)
  );

  // handshakes
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_take  = out_vld && !rsp_stall;
  assign out_free  = !out_vld || out_take;
  assign rsp_valid = out_vld;
  assign rsp_data  = out_q;

  // commands that do any work
  always_comb begin
    case (req_data.mode)
      MODE_ADD:         start_ok = (req_data.node_id != '0) && (req_data.alias_in != '0);
      MODE_REMOVE:      start_ok = (req_data.alias_in != '0);
      MODE_ALIAS_BY_ID,
      MODE_ID_BY_ALIAS,
      MODE_GENERATE,
      MODE_DUMP:        start_ok = 1'b1;
      default:          start_ok = 1'b0;
    endcase
  end

  // evaluate the slot returned by the RAM; never-written slots read as empty
  assign ent_vld   = valid_bits[pend_idx];
  assign e_id      = ent_vld ? rd_ent.node_id : '0;
  assign e_al      = ent_vld ? rd_ent.alias_val : '0;
  assign occupied  = (e_al != '0);
  assign gen_alias = alias_fold(running_seed);
  assign is_dump   = (op.mode == MODE_DUMP);
  assign is_gen    = (op.mode == MODE_GENERATE);
  assign iss_done  = (iss_cnt == CNT_W'(ENTRIES));

  always_comb begin
    case (op.mode)
      MODE_ADD:         match = !occupied;
      MODE_REMOVE,
      MODE_ID_BY_ALIAS: match = (e_al == op.alias_in) && (op.alias_in != '0);
      MODE_ALIAS_BY_ID: match = (e_id == op.node_id) && (op.node_id != '0);
      MODE_GENERATE:    match = (e_al == gen_alias);
      default:          match = 1'b0;
    endcase
  end

  // a dump entry cannot move on while lookahead and output are both full
  assign eval_block = (state == ST_SCAN) && is_dump && pend && occupied
                      && hold_vld && !out_free;
  assign eval_fire  = pend && !eval_block;

  // next state and control
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    retry      = 1'b0;
    seed_step  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = found_idx;
    wr_ent     = found_ent;
    res_load   = 1'b0;
    res_next   = '0;
    out_load   = 1'b0;
    out_next   = res;
    case (state)
      ST_IDLE: begin
        if (accept && start_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (is_gen && (gen_alias == '0) && (iss_cnt == '0) && !pend) begin
          // zero candidate: step and try again without scanning
          retry     = 1'b1;
          seed_step = 1'b1;
        end else begin
          issue = !eval_block && !iss_done;
          // push the previous dump entry when a newer one turns up
          if (is_dump && pend && occupied && hold_vld && out_free) begin
            out_load = 1'b1;
            out_next = hold;
          end
          if (iss_done && !pend) begin
            case (op.mode)
              MODE_ADD: begin
                wr_en      = 1'b1;
                wr_addr    = found ? found_idx : best_idx;
                wr_ent     = '{node_id: op.node_id, alias_val: op.alias_in, stamp: op.now};
                state_next = ST_IDLE;
              end
              MODE_REMOVE: begin
                wr_en      = found;
                wr_ent     = '{node_id: found_ent.node_id, alias_val: '0,
                               stamp: found_ent.stamp};
                state_next = ST_IDLE;
              end
              MODE_ALIAS_BY_ID: begin
                res_load              = 1'b1;
                res_next.result_alias = found ? found_ent.alias_val : '0;
                res_next.last         = 1'b1;
                state_next            = ST_RESULT;
              end
              MODE_ID_BY_ALIAS: begin
                res_load           = 1'b1;
                res_next.result_id = found ? found_ent.node_id : '0;
                res_next.last      = 1'b1;
                state_next         = ST_RESULT;
              end
              MODE_GENERATE: begin
                seed_step = 1'b1;
                if (found) begin
                  retry = 1'b1;
                end else begin
                  res_load              = 1'b1;
                  res_next.result_alias = gen_alias;
                  res_next.last         = 1'b1;
                  state_next            = ST_RESULT;
                end
              end
              MODE_DUMP: begin
                res_load = 1'b1;
                if (hold_vld) begin
                  res_next = hold;
                end
                res_next.last = 1'b1;
                state_next    = ST_RESULT;
              end
              default: begin
                state_next = ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_next   = res;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign scan_clear = accept || retry;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan control and tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cnt  <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      best_vld <= 1'b0;
      hold_vld <= 1'b0;
    end else begin
      if (scan_clear) begin
        iss_cnt <= '0;
      end else if (issue) begin
        iss_cnt <= iss_cnt + 1'b1;
      end
      pend <= eval_block || issue;
      if (scan_clear) begin
        found    <= 1'b0;
        best_vld <= 1'b0;
        hold_vld <= 1'b0;
      end else if (eval_fire) begin
        if (match && !found) begin
          found <= 1'b1;
        end
        if (occupied && (!best_vld || rd_ent.stamp < best_stamp)) begin
          best_vld <= 1'b1;
        end
        if (is_dump && occupied) begin
          hold_vld <= 1'b1;
        end
      end
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx <= iss_cnt[IDX_W-1:0];
    end
    if (accept) begin
      op <= req_data;
    end
    if (eval_fire) begin
      if (match && !found) begin
        found_idx <= pend_idx;
        found_ent <= '{node_id: e_id, alias_val: e_al, stamp: rd_ent.stamp};
      end
      if (occupied && (!best_vld || rd_ent.stamp < best_stamp)) begin
        best_stamp <= rd_ent.stamp;
        best_idx   <= pend_idx;
      end
      if (is_dump && occupied) begin
        hold <= '{result_id: e_id, result_alias: e_al, entry_valid: 1'b1, last: 1'b0};
      end
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (out_take) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= out_next;
    end
  end

  // slot valid flags and generator seed
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      running_seed <= '0;
    end else begin
      if (wr_en) begin
        valid_bits[wr_addr] <= 1'b1;
      end
      if (cfg_wr_en) begin
        running_seed <= cfg_wr_data;
      end else if (seed_step) begin
        running_seed <= lcg_next(running_seed);
      end
    end
  end

`ifndef SYNTHESIS
  // no read in flight while idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("read pending while idle");

  // table is written only after the scan has drained
  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!pend && iss_done && (state == ST_SCAN)))
    else $error("table write during scan");

  // a dumped entry always carries a live alias
  a_dump_alias: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.entry_valid) |-> (rsp_data.result_alias != '0))
    else $error("dumped entry with zero alias");

  // issue counter stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    iss_cnt <= CNT_W'(ENTRIES))
    else $error("scan counter out of range");
`endif

endmodule

// ===== src/nat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
